// ===== sv/ssc_pkg.sv =====
package ssc_pkg;

   localparam int COORD_W    = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int DOT_W      = PROD_W + 2;
   localparam int BIG_W      = 2 * DOT_W + 1;
   localparam int PARAM_BITS = 32;
   localparam int S_W        = PARAM_BITS + 1;
   localparam int CSR_W      = 32;
   localparam int CSR_AW     = 2;
   // byte address of the parallel threshold register
   localparam logic [CSR_AW-1:0] CSR_THR_ADDR = '0;
   // divider: input register, one register per quotient bit, output register
   localparam int DIV_LAT    = PARAM_BITS + 2;
   // vector side line from the difference stage to the divider outputs
   localparam int SIDE_LAT   = 6 + DIV_LAT;
   // accept edge to the edge at which the result beat is taken
   localparam int PIPE_DEPTH = SIDE_LAT + 3;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] u;
      logic [2:0][DIFF_W-1:0] v;
      logic [2:0][DIFF_W-1:0] w;
   } vec_type;

endpackage

// ===== sv/ssc_mul.sv =====
module ssc_mul (
   input  logic                                clock,
   input  logic signed [ssc_pkg::DOT_W-1:0]    op_a,
   input  logic signed [ssc_pkg::DOT_W-1:0]    op_b,
   output logic signed [2*ssc_pkg::DOT_W-1:0]  prod
);
   import ssc_pkg::*;

   localparam int LO_W  = DOT_W / 2;
   localparam int HI_W  = DOT_W - LO_W;
   localparam int MID_W = LO_W + HI_W + 2;

   logic        [LO_W-1:0]          a_lo, b_lo;
   logic signed [HI_W-1:0]          a_hi, b_hi;
   logic        [2*LO_W-1:0]        ll_in, ll_ff;
   logic signed [LO_W+HI_W:0]       lh_in, lh_ff, hl_in, hl_ff;
   logic signed [2*HI_W-1:0]        hh_in, hh_ff;
   logic signed [MID_W-1:0]         mid;
   logic signed [2*DOT_W-1:0]       prod_in, prod_ff;

   assign a_lo = op_a[LO_W-1:0];
   assign b_lo = op_b[LO_W-1:0];
   assign a_hi = op_a[DOT_W-1:LO_W];
   assign b_hi = op_b[DOT_W-1:LO_W];

   // four partial products, registered before they are summed
   assign ll_in = a_lo * b_lo;
   assign lh_in = $signed({1'b0, a_lo}) * b_hi;
   assign hl_in = a_hi * $signed({1'b0, b_lo});
   assign hh_in = a_hi * b_hi;

   assign mid = MID_W'(lh_ff) + MID_W'(hl_ff);
   assign prod_in = $signed({hh_ff, {(2*LO_W){1'b0}}})
                  + $signed({{(2*DOT_W-MID_W-LO_W){mid[MID_W-1]}}, mid, {LO_W{1'b0}}})
                  + $signed({{(2*DOT_W-2*LO_W){1'b0}}, ll_ff});

   always_ff @(posedge clock) begin
      ll_ff   <= ll_in;
      lh_ff   <= lh_in;
      hl_ff   <= hl_in;
      hh_ff   <= hh_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== sv/ssc_div.sv =====
module ssc_div (
   input  logic                              clock,
   input  logic signed [ssc_pkg::BIG_W-1:0]  num,
   input  logic signed [ssc_pkg::BIG_W-1:0]  den,
   output logic        [ssc_pkg::S_W-1:0]    quo
);
   import ssc_pkg::*;

   localparam logic signed [BIG_W-1:0] BIG_ZERO = '0;

   logic signed [BIG_W-1:0]      num_ff, den0_ff;
   logic                         zero_in, one_in;
   logic        [BIG_W-1:0]      r_ff   [PARAM_BITS];
   logic        [BIG_W-1:0]      d_ff   [PARAM_BITS];
   logic        [PARAM_BITS-1:0] q_ff   [PARAM_BITS];
   logic                         zero_ff[PARAM_BITS];
   logic                         one_ff [PARAM_BITS];
   logic        [S_W-1:0]        quo_in, quo_ff;

   // clamps: non-positive numerator gives 0, numerator at or above den gives 1
   assign zero_in = (num_ff <= BIG_ZERO);
   assign one_in  = (num_ff >= den0_ff);

   always_ff @(posedge clock) begin
      num_ff  <= num;
      den0_ff <= den;
   end

   // one restoring step per stage
   for (genvar k = 0; k < PARAM_BITS; k++) begin : g_step
      logic [BIG_W-1:0]      r_prev, d_prev;
      logic [PARAM_BITS-1:0] q_prev;
      logic                  z_prev, o_prev;
      logic [BIG_W:0]        r_sh;
      logic                  ge;

      if (k == 0) begin : g_first
         assign r_prev = num_ff;
         assign d_prev = den0_ff;
         assign q_prev = '0;
         assign z_prev = zero_in;
         assign o_prev = one_in;
      end else begin : g_next
         assign r_prev = r_ff[k-1];
         assign d_prev = d_ff[k-1];
         assign q_prev = q_ff[k-1];
         assign z_prev = zero_ff[k-1];
         assign o_prev = one_ff[k-1];
      end

      assign r_sh = {r_prev, 1'b0};
      assign ge   = (r_sh >= {1'b0, d_prev});

      always_ff @(posedge clock) begin
         r_ff[k]    <= ge ? BIG_W'(r_sh - {1'b0, d_prev}) : BIG_W'(r_sh);
         d_ff[k]    <= d_prev;
         q_ff[k]    <= {q_prev[PARAM_BITS-2:0], ge};
         zero_ff[k] <= z_prev;
         one_ff[k]  <= o_prev;
      end
   end

   always_comb begin
      priority if (zero_ff[PARAM_BITS-1]) begin
         quo_in = '0;
      end else if (one_ff[PARAM_BITS-1]) begin
         quo_in = S_W'(1) << PARAM_BITS;
      end else begin
         quo_in = {1'b0, q_ff[PARAM_BITS-1]};
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

// ===== sv/segment_segment_closest_vector.sv =====
// Closest-approach vector between two 3D segments A and B, one pair per beat,
// coordinates in signed Q16.16. Pulse start with a segment pair on the req_
// ports; busy never rises, so a new pair may be issued every cycle. Exactly one
// result beat per pair appears on the rsp_ ports with rsp_strobe high for one
// cycle, in issue order. The receiver cannot stall the block; the delay from
// accept to result is set by the 32-stage restoring divider that forms the
// segment parameters, the wide dot product and determinant multiplier stages
// ahead of it and the gap product and rounding stages after it. The result is
// A's closest point minus B's closest point, rounded to nearest and saturated
// per component. parallel_threshold (APB register 0, reset 1) sets the
// determinant at or below which the segments are treated as parallel; write
// it only while no pair is in flight.
module segment_segment_closest_vector
   import ssc_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              start,
   output logic                              busy,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_a_start_x,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_a_start_y,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_a_start_z,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_a_end_x,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_a_end_y,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_a_end_z,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_b_start_x,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_b_start_y,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_b_start_z,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_b_end_x,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_b_end_y,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_b_end_z,

   output logic                              rsp_strobe,
   output logic signed [ssc_pkg::COORD_W-1:0] rsp_gap_x,
   output logic signed [ssc_pkg::COORD_W-1:0] rsp_gap_y,
   output logic signed [ssc_pkg::COORD_W-1:0] rsp_gap_z,

   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ssc_pkg::CSR_AW-1:0]        paddr,
   input  logic [ssc_pkg::CSR_W-1:0]         pwdata,
   output logic [ssc_pkg::CSR_W-1:0]         prdata,
   output logic                              pready
);

   // s parameter selection after the first solve
   localparam logic [1:0] S_ZERO = 2'd0;
   localparam logic [1:0] S_ONE  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;

   localparam int G_W   = DIFF_W + S_W + 3;
   localparam int SAT_W = G_W - PARAM_BITS;

   localparam logic signed [BIG_W-1:0] BIG_ZERO = '0;
   localparam logic signed [BIG_W-1:0] BIG_ONE  = BIG_W'(1);
   localparam logic signed [SAT_W-1:0] SAT_MAX  = SAT_W'({1'b0, {(COORD_W-1){1'b1}}});
   localparam logic signed [SAT_W-1:0] SAT_MIN  = -SAT_MAX - SAT_W'(1);

   // ---------------- configuration ----------------
   logic [CSR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= CSR_W'(1);
      end else if (psel && penable && pwrite) begin
         thr_ff <= pwdata;
      end
   end

   // the threshold reads back at its own address, other offsets read zero
   assign prdata = (paddr == CSR_THR_ADDR) ? thr_ff : '0;
   assign pready = 1'b1;
   assign busy   = 1'b0;

   // ---------------- valid line ----------------
   logic [PIPE_DEPTH-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], start};
      end
   end

   assign rsp_strobe = vld_ff[PIPE_DEPTH-1];

   // ---------------- stage 1: u, v, w0 ----------------
   logic signed [COORD_W-1:0] as_c[3], ae_c[3], bs_c[3], be_c[3];
   vec_type vec_in, vec_ff;

   assign as_c = '{req_a_start_x, req_a_start_y, req_a_start_z};
   assign ae_c = '{req_a_end_x,   req_a_end_y,   req_a_end_z};
   assign bs_c = '{req_b_start_x, req_b_start_y, req_b_start_z};
   assign be_c = '{req_b_end_x,   req_b_end_y,   req_b_end_z};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vec_in.u[k] = DIFF_W'(ae_c[k]) - DIFF_W'(as_c[k]);
         vec_in.v[k] = DIFF_W'(be_c[k]) - DIFF_W'(bs_c[k]);
         // w0 = A start minus B start
         vec_in.w[k] = DIFF_W'(as_c[k]) - DIFF_W'(bs_c[k]);
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   // ---------------- stage 2: fifteen coordinate products ----------------
   logic signed [PROD_W-1:0] uu_ff[3], uv_ff[3], vv_ff[3], uw_ff[3], vw_ff[3];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         uu_ff[k] <= $signed(vec_ff.u[k]) * $signed(vec_ff.u[k]);
         uv_ff[k] <= $signed(vec_ff.u[k]) * $signed(vec_ff.v[k]);
         vv_ff[k] <= $signed(vec_ff.v[k]) * $signed(vec_ff.v[k]);
         uw_ff[k] <= $signed(vec_ff.u[k]) * $signed(vec_ff.w[k]);
         vw_ff[k] <= $signed(vec_ff.v[k]) * $signed(vec_ff.w[k]);
      end
   end

   // ---------------- stage 3: dot products ----------------
   logic signed [DOT_W-1:0] a3_ff, b3_ff, c3_ff, d3_ff, e3_ff;

   always_ff @(posedge clock) begin
      a3_ff <= DOT_W'(uu_ff[0]) + DOT_W'(uu_ff[1]) + DOT_W'(uu_ff[2]);
      b3_ff <= DOT_W'(uv_ff[0]) + DOT_W'(uv_ff[1]) + DOT_W'(uv_ff[2]);
      c3_ff <= DOT_W'(vv_ff[0]) + DOT_W'(vv_ff[1]) + DOT_W'(vv_ff[2]);
      d3_ff <= DOT_W'(uw_ff[0]) + DOT_W'(uw_ff[1]) + DOT_W'(uw_ff[2]);
      e3_ff <= DOT_W'(vw_ff[0]) + DOT_W'(vw_ff[1]) + DOT_W'(vw_ff[2]);
   end

   // ---------------- stages 4 and 5: wide products ----------------
   logic signed [2*DOT_W-1:0] ac_w, bb_w, be_w, cd_w, ae_w, bd_w;
   logic signed [DOT_W-1:0]   a4_ff, b4_ff, c4_ff, d4_ff, e4_ff;
   logic signed [DOT_W-1:0]   a5_ff, b5_ff, c5_ff, d5_ff, e5_ff;

   ssc_mul u_mul_ac (.clock(clock), .op_a(a3_ff), .op_b(c3_ff), .prod(ac_w));
   ssc_mul u_mul_bb (.clock(clock), .op_a(b3_ff), .op_b(b3_ff), .prod(bb_w));
   ssc_mul u_mul_be (.clock(clock), .op_a(b3_ff), .op_b(e3_ff), .prod(be_w));
   ssc_mul u_mul_cd (.clock(clock), .op_a(c3_ff), .op_b(d3_ff), .prod(cd_w));
   ssc_mul u_mul_ae (.clock(clock), .op_a(a3_ff), .op_b(e3_ff), .prod(ae_w));
   ssc_mul u_mul_bd (.clock(clock), .op_a(b3_ff), .op_b(d3_ff), .prod(bd_w));

   always_ff @(posedge clock) begin
      a4_ff <= a3_ff;  b4_ff <= b3_ff;  c4_ff <= c3_ff;  d4_ff <= d3_ff;  e4_ff <= e3_ff;
      a5_ff <= a4_ff;  b5_ff <= b4_ff;  c5_ff <= c4_ff;  d5_ff <= d4_ff;  e5_ff <= e4_ff;
   end

   // ---------------- stage 6: determinant and numerators ----------------
   logic signed [BIG_W-1:0] dd6_ff, sn6_ff, tn6_ff;
   logic signed [DOT_W-1:0] a6_ff, b6_ff, c6_ff, d6_ff, e6_ff;

   always_ff @(posedge clock) begin
      dd6_ff <= BIG_W'(ac_w) - BIG_W'(bb_w);
      sn6_ff <= BIG_W'(be_w) - BIG_W'(cd_w);
      tn6_ff <= BIG_W'(ae_w) - BIG_W'(bd_w);
      a6_ff  <= a5_ff;  b6_ff <= b5_ff;  c6_ff <= c5_ff;  d6_ff <= d5_ff;  e6_ff <= e5_ff;
   end

   // ---------------- stage 7: first solve for s ----------------
   logic                    par6, sneg6, sgt6;
   logic [1:0]              smode_in, smode_ff;
   logic signed [BIG_W-1:0] tn_in, td_in;
   logic signed [BIG_W-1:0] sn7_ff, dd7_ff, tn7_ff, td7_ff;
   logic signed [DOT_W-1:0] a7_ff, b7_ff, d7_ff;

   assign par6  = (dd6_ff <= $signed({{(BIG_W-CSR_W){1'b0}}, thr_ff}));
   assign sneg6 = sn6_ff[BIG_W-1];
   assign sgt6  = (sn6_ff > dd6_ff);

   always_comb begin
      priority if (par6 || sneg6) begin
         smode_in = S_ZERO;
         tn_in    = BIG_W'(e6_ff);
         td_in    = BIG_W'(c6_ff);
      end else if (sgt6) begin
         smode_in = S_ONE;
         tn_in    = BIG_W'(e6_ff) + BIG_W'(b6_ff);
         td_in    = BIG_W'(c6_ff);
      end else begin
         smode_in = S_DIV;
         tn_in    = tn6_ff;
         td_in    = dd6_ff;
      end
   end

   always_ff @(posedge clock) begin
      smode_ff <= smode_in;
      sn7_ff   <= sn6_ff;
      dd7_ff   <= dd6_ff;
      tn7_ff   <= tn_in;
      td7_ff   <= td_in;
      a7_ff    <= a6_ff;
      b7_ff    <= b6_ff;
      d7_ff    <= d6_ff;
   end

   // ---------------- t clamp and divider operands ----------------
   // constant parameters go through the divider as 0/1 and 1/1
   logic signed [BIG_W-1:0] s_num, s_den, t_num, t_den;

   always_comb begin
      priority if (tn7_ff[BIG_W-1]) begin
         // t clamps to 0, s re-solved against A alone
         t_num = BIG_ZERO;
         t_den = BIG_ONE;
         s_num = -BIG_W'(d7_ff);
         s_den = BIG_W'(a7_ff);
      end else if (tn7_ff > td7_ff) begin
         t_num = BIG_ONE;
         t_den = BIG_ONE;
         s_num = BIG_W'(b7_ff) - BIG_W'(d7_ff);
         s_den = BIG_W'(a7_ff);
      end else begin
         t_num = tn7_ff;
         t_den = td7_ff;
         unique case (smode_ff)
            S_ONE: begin
               s_num = BIG_ONE;
               s_den = BIG_ONE;
            end
            S_DIV: begin
               s_num = sn7_ff;
               s_den = dd7_ff;
            end
            default: begin
               s_num = BIG_ZERO;
               s_den = BIG_ONE;
            end
         endcase
      end
   end

   logic [S_W-1:0] s_q, t_q;

   ssc_div u_div_s (.clock(clock), .num(s_num), .den(s_den), .quo(s_q));
   ssc_div u_div_t (.clock(clock), .num(t_num), .den(t_den), .quo(t_q));

   // ---------------- vector side line ----------------
   vec_type side_ff[SIDE_LAT];

   always_ff @(posedge clock) begin
      side_ff[0] <= vec_ff;
      for (int i = 1; i < SIDE_LAT; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // ---------------- gap products ----------------
   logic signed [DIFF_W+S_W:0] us_ff[3], vt_ff[3];
   logic signed [DIFF_W-1:0]   wg_ff[3];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         us_ff[k] <= $signed(side_ff[SIDE_LAT-1].u[k]) * $signed({1'b0, s_q});
         vt_ff[k] <= $signed(side_ff[SIDE_LAT-1].v[k]) * $signed({1'b0, t_q});
         wg_ff[k] <= side_ff[SIDE_LAT-1].w[k];
      end
   end

   // ---------------- sum, round, saturate ----------------
   logic signed [G_W-1:0]     g_c[3];
   logic signed [SAT_W-1:0]   gs_c[3];
   logic signed [COORD_W-1:0] gap_in[3], gap_ff[3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         g_c[k] = (G_W'(wg_ff[k]) <<< PARAM_BITS) + G_W'(us_ff[k]) - G_W'(vt_ff[k])
                + (G_W'(1) <<< (PARAM_BITS - 1));
         gs_c[k] = SAT_W'(g_c[k] >>> PARAM_BITS);
         priority if (gs_c[k] > SAT_MAX) begin
            gap_in[k] = COORD_W'(SAT_MAX);
         end else if (gs_c[k] < SAT_MIN) begin
            gap_in[k] = COORD_W'(SAT_MIN);
         end else begin
            gap_in[k] = COORD_W'(gs_c[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      gap_ff <= gap_in;
   end

   assign rsp_gap_x = gap_ff[0];
   assign rsp_gap_y = gap_ff[1];
   assign rsp_gap_z = gap_ff[2];

endmodule

// ===== sv/ssc_chk.sv =====
module ssc_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_strobe,
   input logic                               psel,
   input logic                               penable,
   input logic                               pwrite,
   input logic [ssc_pkg::CSR_AW-1:0]         paddr,
   input logic [ssc_pkg::CSR_W-1:0]          pwdata,
   input logic [ssc_pkg::CSR_W-1:0]          prdata,
   input logic                               pready
);
   import ssc_pkg::*;

   // every result beat traces back to an accepted pair a fixed latency earlier
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, PIPE_DEPTH))
      else $error("result beat without a pair accepted at the pipeline latency");

   // a threshold write is visible on the next read of its address
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready) |=>
         (paddr != CSR_THR_ADDR || prdata == $past(pwdata)))
      else $error("threshold readback mismatch");

   // threshold holds when nothing writes it
   a_csr_hold: assert property (@(posedge clock) disable iff (reset)
      !(psel && penable && pwrite) && !$past(reset) |=>
         (!$stable(paddr) || $stable(prdata)))
      else $error("threshold changed without a write");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy && pready)
      else $error("block refused a beat");

endmodule

bind segment_segment_closest_vector ssc_chk u_ssc_chk (.*);

// ===== dv/tb_segment_segment_closest_vector.sv =====
module tb_segment_segment_closest_vector;
   timeunit 1ns;
   timeprecision 1ps;
   import ssc_pkg::*;

   // exact signed arithmetic, wide enough for every intermediate product
   typedef logic signed [255:0] wide_type;

   // one segment pair: a_start xyz, a_end xyz, b_start xyz, b_end xyz
   typedef struct packed {
      logic [11:0][COORD_W-1:0] p;
   } pair_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] g;
   } gap_type;

   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_W-1:0] req_f [12] = '{default: '0};
   logic rsp_strobe;
   logic signed [COORD_W-1:0] rsp_gap_x, rsp_gap_y, rsp_gap_z;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_W-1:0] pwdata = '0;
   logic [CSR_W-1:0] prdata;
   logic pready;

   pair_type pending_pairs[$];
   gap_type  expected_gaps[$];
   pair_type cur_pair;
   logic [31:0] threshold = 32'd1;
   int idle_pct = 0;
   int fail_count = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   segment_segment_closest_vector u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_start_x(req_f[0]), .req_a_start_y(req_f[1]), .req_a_start_z(req_f[2]),
      .req_a_end_x(req_f[3]), .req_a_end_y(req_f[4]), .req_a_end_z(req_f[5]),
      .req_b_start_x(req_f[6]), .req_b_start_y(req_f[7]), .req_b_start_z(req_f[8]),
      .req_b_end_x(req_f[9]), .req_b_end_y(req_f[10]), .req_b_end_z(req_f[11]),
      .rsp_strobe(rsp_strobe), .rsp_gap_x(rsp_gap_x), .rsp_gap_y(rsp_gap_y),
      .rsp_gap_z(rsp_gap_z),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // segment parameter num/den as unsigned Q1.32, clamped to [0,1]
   function automatic wide_type param_quot(wide_type num, wide_type den);
      wide_type one_p;
      one_p = wide_type'(1) <<< PARAM_BITS;
      if (num <= 0) return 0;
      if (num >= den) return one_p;
      return (num <<< PARAM_BITS) / den;
   endfunction

   // closest point of A minus closest point of B, rounded and saturated
   function automatic gap_type closest_gap(pair_type pr, logic [31:0] thr);
      wide_type x [12];
      wide_type u [3], v [3], w [3];
      wide_type a, b, c, d, e, det, sn, tn, td, s, t, g, one_p, maxv, minv;
      gap_type r;
      one_p = wide_type'(1) <<< PARAM_BITS;
      maxv = wide_type'(32'sh7fff_ffff);
      minv = -maxv - 1;
      for (int i = 0; i < 12; i++) x[i] = wide_type'($signed(pr.p[i]));
      for (int k = 0; k < 3; k++) begin
         u[k] = x[3+k] - x[k];
         v[k] = x[9+k] - x[6+k];
         w[k] = x[k] - x[6+k];
      end
      a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
      b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
      c = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
      d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
      e = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
      det = a*c - b*b;
      if (det <= wide_type'({1'b0, thr})) begin
         // parallel: pin s to the start of A
         s = 0; tn = e; td = c;
      end else begin
         sn = b*e - c*d;
         tn = a*e - b*d;
         td = det;
         if (sn < 0) begin
            s = 0; tn = e; td = c;
         end else if (sn > det) begin
            s = one_p; tn = e + b; td = c;
         end else begin
            s = param_quot(sn, det);
         end
      end
      // clamp t, re-solve s against the clamped end; degenerate A keeps s at zero
      if (tn < 0) begin
         t = 0;
         s = (a == 0) ? 0 : param_quot(-d, a);
      end else if (tn > td) begin
         t = one_p;
         s = (a == 0) ? 0 : param_quot(b - d, a);
      end else begin
         t = param_quot(tn, td);
      end
      for (int k = 0; k < 3; k++) begin
         g = (w[k] <<< PARAM_BITS) + u[k]*s - v[k]*t + (wide_type'(1) <<< (PARAM_BITS-1));
         g = g >>> PARAM_BITS;
         if (g > maxv) g = maxv;
         if (g < minv) g = minv;
         r.g[k] = g[COORD_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] small_coord();
      return $unsigned($urandom_range(0, 32'h000f_ffff) - 32'h0008_0000);
   endfunction

   function automatic logic [31:0] corner_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // random pair of a given flavor
   function automatic pair_type make_pair(int kind);
      pair_type pr;
      int m;
      for (int i = 0; i < 12; i++) pr.p[i] = (kind == 0) ? $urandom : small_coord();
      case (kind)
         2: begin
            // B end is B start plus A's extent scaled (parallel), then B start may move near A start
            m = $urandom_range(0, 4) - 2;
            for (int k = 0; k < 3; k++) begin
               pr.p[9+k] = pr.p[6+k] + (pr.p[3+k] - pr.p[k]) * m;
               if ($urandom_range(0, 1)) pr.p[6+k] = pr.p[k] + (pr.p[6+k] >>> 12);
            end
         end
         3: for (int k = 0; k < 3; k++) pr.p[3+k] = pr.p[k];
         4: for (int k = 0; k < 3; k++) pr.p[9+k] = pr.p[6+k];
         5: for (int k = 0; k < 3; k++) begin
            pr.p[3+k] = pr.p[k];
            pr.p[9+k] = pr.p[6+k];
         end
         6: for (int i = 0; i < 12; i++) pr.p[i] = corner_coord();
         7: for (int i = 0; i < 12; i++) pr.p[i] = $urandom_range(0, 6) - 3;
         default: ;
      endcase
      return pr;
   endfunction

   // driver: record the beat taken at this edge, then present the next pair
   always @(posedge clock) begin
      logic next_start;
      pair_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            expected_gaps.push_back(closest_gap(cur_pair, threshold));
            next_start = 1'b0;
         end
         if (!(start && busy) && pending_pairs.size() > 0 &&
             $urandom_range(0, 99) >= idle_pct) begin
            nxt = pending_pairs.pop_front();
            cur_pair <= nxt;
            for (int i = 0; i < 12; i++) req_f[i] <= nxt.p[i];
            next_start = 1'b1;
         end
         start <= next_start;
      end
   end

   // monitor: every strobed beat against the oldest prediction
   always @(posedge clock) begin
      gap_type exp_gap;
      if (!reset && rsp_strobe) begin
         if (expected_gaps.size() == 0) begin
            $error("result beat with no pair outstanding");
            fail_count++;
         end else begin
            exp_gap = expected_gaps.pop_front();
            if (rsp_gap_x !== exp_gap.g[0]) begin
               $error("gap_x expected %0d actual %0d", $signed(exp_gap.g[0]), rsp_gap_x);
               fail_count++;
            end
            if (rsp_gap_y !== exp_gap.g[1]) begin
               $error("gap_y expected %0d actual %0d", $signed(exp_gap.g[1]), rsp_gap_y);
               fail_count++;
            end
            if (rsp_gap_z !== exp_gap.g[2]) begin
               $error("gap_z expected %0d actual %0d", $signed(exp_gap.g[2]), rsp_gap_z);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // apb write of the threshold, only while nothing is in flight
   task automatic write_threshold(logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= CSR_THR_ADDR; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      threshold = value;
   endtask

   task automatic drain();
      wait (pending_pairs.size() == 0 && !start && expected_gaps.size() == 0);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   initial begin
      logic [31:0] thr_list [6];
      int idle_list [4];
      pair_type pr;
      thr_list = '{32'd0, 32'hffff_ffff, 32'd1, 32'h0001_0000, 32'h0, 32'h0};
      idle_list = '{0, 48, 7, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, degenerate and parallel cases, reset threshold
      for (int i = 0; i < 12; i++) pr.p[i] = '0;
      pending_pairs.push_back(pr);
      for (int i = 0; i < 12; i++) pr.p[i] = (i < 6) ? 32'h8000_0000 : 32'h7fff_ffff;
      pending_pairs.push_back(pr);
      for (int i = 0; i < 12; i++) pr.p[i] = (i % 6 < 3) ? 32'h8000_0000 : 32'h7fff_ffff;
      pending_pairs.push_back(pr);
      for (int i = 0; i < 12; i++) pr.p[i] = (i % 6 < 3) ? 32'h7fff_ffff : 32'h8000_0000;
      pending_pairs.push_back(pr);
      for (int i = 0; i < 12; i++) pr.p[i] = 32'hffff_ffff;
      pending_pairs.push_back(pr);
      for (int kind = 0; kind < 8; kind++) begin
         pending_pairs.push_back(make_pair(kind));
         pending_pairs.push_back(make_pair(kind));
      end
      drain();

      thr_list[4] = $urandom;
      thr_list[5] = $urandom_range(0, 255);
      for (int ph = 0; ph < 6; ph++) begin
         write_threshold(thr_list[ph]);
         for (int ip = 0; ip < 4; ip++) begin
            idle_pct = idle_list[ip];
            for (int n = 0; n < 27; n++) pending_pairs.push_back(make_pair($urandom_range(0, 7)));
            wait (pending_pairs.size() == 0);
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== segment_segment_closest_vector.f =====
sv/ssc_pkg.sv
sv/ssc_mul.sv
sv/ssc_div.sv
sv/segment_segment_closest_vector.sv
sv/ssc_chk.sv
dv/tb_segment_segment_closest_vector.sv
